### design/spq_pkg.sv
`default_nettype none

package spq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int FIELD_W         = 16;
    localparam int OCC_W           = 5;
    localparam int STATUS_W        = 2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd3;

    // operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    typedef struct packed {
        logic        [FIELD_W-1:0] handle;
        logic        [FIELD_W-1:0] kind;
        logic signed [FIELD_W-1:0] prio;
    } t_entry;

endpackage

`default_nettype wire

### design/spq_mem.sv
`default_nettype none

module spq_mem
    import spq_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_entry        i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_entry             o_rd_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### design/stable_priority_queue.sv
`default_nettype none

// channel  | handshake              | payload
// ---------+------------------------+---------------------------------------------------
// input    | i_in_valid / o_in_stall | i_func i_item_handle i_kind i_priority_req
// output   | o_out_valid / i_out_stall | o_status o_occupancy o_out_handle o_out_kind
//          |                        | o_out_priority
//
// one item at a time: the item is accepted, worked on, then its result is handed over
// insert: scan for a duplicate handle and the first entry of greater priority, then move the tail up
// remove: the head is read and the rest move forward one entry a cycle
// null handle and empty remove skip the work cycles; full and duplicate stop after the scan
// reset (synchronous, active low) empties the queue; entry memory is not cleared
// o_in_stall is high while an item is at work or its result waits for the output register

module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic                       i_func,
    input  wire logic        [FIELD_W-1:0]  i_item_handle,
    input  wire logic        [FIELD_W-1:0]  i_kind,
    input  wire logic signed [FIELD_W-1:0]  i_priority_req,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic             [STATUS_W-1:0] o_status,
    output logic             [OCC_W-1:0]    o_occupancy,
    output logic             [FIELD_W-1:0]  o_out_handle,
    output logic             [FIELD_W-1:0]  o_out_kind,
    output logic signed      [FIELD_W-1:0]  o_out_priority
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_RMV    = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]    r_state;
    logic [CW-1:0] r_count;

    logic        [FIELD_W-1:0]  r_h;
    logic        [FIELD_W-1:0]  r_k;
    logic signed [FIELD_W-1:0]  r_p;

    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_left;
    logic [AW-1:0] r_src;
    logic [AW-1:0] r_cmp_idx;
    logic [AW-1:0] r_pos;
    logic          r_rd_v;
    logic          r_dup;
    logic          r_found;

    logic [STATUS_W-1:0] r_res_status;
    t_entry              r_res;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [OCC_W-1:0]    r_out_occ;
    t_entry              r_out;

    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    t_entry        w_wr_data;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    t_entry        w_rd_data;
    t_entry        w_new;
    logic          w_scan_done;
    logic          w_move_done;
    logic [AW-1:0] w_ins_pos;
    logic          w_out_free;
    logic [CW+OCC_W-1:0] w_occ_ext;

    spq_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_new       = '{handle: r_h, kind: r_k, prio: r_p};
    assign w_scan_done = (r_idx == r_count) && !r_rd_v;
    assign w_move_done = (r_left == '0) && !r_rd_v;
    assign w_ins_pos   = r_found ? r_pos : r_count[AW-1:0];
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_occ_ext   = {{OCC_W{1'b0}}, r_count};

    // memory port steering
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = r_src;
        w_wr_en   = 1'b0;
        w_wr_addr = r_pos;
        w_wr_data = w_rd_data;
        unique case (r_state)
            S_SCAN: begin
                w_rd_en   = (r_idx < r_count);
                w_rd_addr = r_idx[AW-1:0];
            end
            S_SHIFT: begin
                w_rd_en = (r_left != '0);
                if (r_rd_v) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_cmp_idx + AW'(1);
                end else if (r_left == '0) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_pos;
                    w_wr_data = w_new;
                end
            end
            S_RMV: begin
                w_rd_en = (r_left != '0);
                if (r_rd_v && (r_cmp_idx != '0)) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_cmp_idx - AW'(1);
                end
            end
            S_IDLE, S_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_rd_v  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_h     <= i_item_handle;
                        r_k     <= i_kind;
                        r_p     <= i_priority_req;
                        r_res   <= '0;
                        r_idx   <= '0;
                        r_src   <= '0;
                        r_left  <= r_count;
                        r_rd_v  <= 1'b0;
                        r_dup   <= 1'b0;
                        r_found <= 1'b0;
                        if (i_func == FUNC_REMOVE) begin
                            if (r_count == '0) begin
                                r_res_status <= ST_EMPTY;
                                r_state      <= S_FINISH;
                            end else begin
                                r_state <= S_RMV;
                            end
                        end else if (i_item_handle == '0) begin
                            r_res_status <= ST_BAD_HANDLE;
                            r_state      <= S_FINISH;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // compare the entry read last cycle
                    if (r_rd_v) begin
                        if (w_rd_data.handle == r_h) begin
                            r_dup <= 1'b1;
                        end
                        if (!r_found && (w_rd_data.prio > r_p)) begin
                            r_found <= 1'b1;
                            r_pos   <= r_cmp_idx;
                        end
                    end
                    r_rd_v <= w_rd_en;
                    if (w_rd_en) begin
                        r_cmp_idx <= r_idx[AW-1:0];
                        r_idx     <= r_idx + CW'(1);
                    end
                    if (w_scan_done) begin
                        if (r_dup) begin
                            r_res_status <= ST_BAD_HANDLE;
                            r_state      <= S_FINISH;
                        end else if (r_count >= DEPTH_C) begin
                            r_res_status <= ST_FULL;
                            r_state      <= S_FINISH;
                        end else begin
                            r_pos   <= w_ins_pos;
                            r_left  <= r_count - CW'(w_ins_pos);
                            r_src   <= r_count[AW-1:0] - AW'(1);
                            r_state <= S_SHIFT;
                        end
                    end
                end
                S_SHIFT: begin
                    // tail moves up from the last entry toward the slot
                    r_rd_v <= w_rd_en;
                    if (w_rd_en) begin
                        r_cmp_idx <= r_src;
                        r_src     <= r_src - AW'(1);
                        r_left    <= r_left - CW'(1);
                    end
                    if (w_move_done) begin
                        r_count      <= r_count + CW'(1);
                        r_res_status <= ST_OK;
                        r_state      <= S_FINISH;
                    end
                end
                S_RMV: begin
                    if (r_rd_v && (r_cmp_idx == '0)) begin
                        r_res <= w_rd_data;
                    end
                    r_rd_v <= w_rd_en;
                    if (w_rd_en) begin
                        r_cmp_idx <= r_src;
                        r_src     <= r_src + AW'(1);
                        r_left    <= r_left - CW'(1);
                    end
                    if (w_move_done) begin
                        r_count      <= r_count - CW'(1);
                        r_res_status <= ST_OK;
                        r_state      <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_FINISH) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FINISH) && w_out_free) begin
            r_out_status <= r_res_status;
            r_out_occ    <= w_occ_ext[OCC_W-1:0];
            r_out        <= r_res;
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_occupancy    = r_out_occ;
    assign o_out_handle   = r_out.handle;
    assign o_out_kind     = r_out.kind;
    assign o_out_priority = r_out.prio;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("queue count beyond depth");

    a_finish_loads : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) && w_out_free |=> o_out_valid)
        else $error("result not presented after finish");

    a_insert_grows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) && w_move_done |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not add one entry");

    a_write_only_moving : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_state == S_SHIFT) || (r_state == S_RMV))
        else $error("entry memory written outside a move");

    a_remove_shrinks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RMV) && w_move_done |=> r_count == $past(r_count) - CW'(1))
        else $error("remove did not take one entry");

endmodule

`default_nettype wire
